[rtl/signed_integer_to_radix_symbols_unit_macros.svh]
// Assertion macros shared by the signed integer to radix symbols unit.
// Used by the modules that carry concurrent checks; needs no other file.
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_UNIT_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIRS_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("sirs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIRS_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("sirs assertion failed");

`endif

[rtl/sirs_pkg.sv]
// Package for the signed integer to radix symbols unit: sizes, codes,
// reset values, controller/datapath structs and the symbol lookup.
// Depends on nothing.
`timescale 1ns / 1ps

package sirs_pkg;

	localparam int NUMBER_WIDTH = 32;
	localparam int MAX_BASE     = 16;
	localparam int SYM_W        = 8;
	localparam int BASE_W       = 5;
	localparam int DIGIT_W      = 4;
	localparam int CNT_W        = 6;
	localparam int STACK_AW     = 5;
	localparam int DIV_STEPS    = 4;
	localparam int DIV_CYCLES   = NUMBER_WIDTH / DIV_STEPS;
	localparam int STEP_W       = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_W        = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

	localparam logic [BASE_W-1:0] BASE_SIZE_RST    = 5'd10;
	localparam logic [CFG_W-1:0]  SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0]  SYMBOLS_HIGH_RST = 64'h4645_4443_4241_3938;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_en;
		logic rd_en;
		logic cnt_dec;
		logic out_load;
		logic out_minus;
	} sirs_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic neg;
		logic digit_done;
		logic conv_done;
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
	} sirs_stat_t;

	function automatic logic [SYM_W-1:0] symbol_at(input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi, input logic [DIGIT_W-1:0] idx);
		logic [CFG_W-1:0] word;
		word = idx[DIGIT_W-1] ? hi : lo;
		return word[{idx[DIGIT_W-2:0], 3'b000} +: SYM_W];
	endfunction

endpackage

[rtl/sirs_cfg.sv]
// Configuration registers and alphabet check of the radix symbols unit.
// Depends on sirs_pkg.
`timescale 1ns / 1ps

module sirs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [sirs_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [sirs_pkg::CFG_W-1:0]     wr_data,
	output logic [sirs_pkg::BASE_W-1:0]    base_size,
	output logic [sirs_pkg::CFG_W-1:0]     symbols_low,
	output logic [sirs_pkg::CFG_W-1:0]     symbols_high,
	output logic                          alpha_ok
);
	import sirs_pkg::*;

	logic [BASE_W-1:0] base_size_q;
	logic [CFG_W-1:0]  symbols_low_q;
	logic [CFG_W-1:0]  symbols_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q    <= BASE_SIZE_RST;
			symbols_low_q  <= SYMBOLS_LOW_RST;
			symbols_high_q <= SYMBOLS_HIGH_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_BASE_SIZE:    base_size_q    <= wr_data[BASE_W-1:0];
				CFG_SYMBOLS_LOW:  symbols_low_q  <= wr_data;
				CFG_SYMBOLS_HIGH: symbols_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Radix range, sign/NUL and pairwise checks of the symbols in use: all compares are independent.
	always_comb begin
		logic [SYM_W-1:0] si;
		alpha_ok = (base_size_q >= BASE_W'(2)) && (base_size_q <= BASE_W'(MAX_BASE));
		for (int i = 0; i < MAX_BASE; i++) begin
			si = symbol_at(symbols_low_q, symbols_high_q, DIGIT_W'(i));
			if (BASE_W'(i) < base_size_q) begin
				if (si == SYM_NUL || si == SYM_PLUS || si == SYM_MINUS)
					alpha_ok = 1'b0;
				for (int j = i + 1; j < MAX_BASE; j++) begin
					if (BASE_W'(j) < base_size_q &&
							symbol_at(symbols_low_q, symbols_high_q, DIGIT_W'(j)) == si)
						alpha_ok = 1'b0;
				end
			end
		end
	end

	assign base_size    = base_size_q;
	assign symbols_low  = symbols_low_q;
	assign symbols_high = symbols_high_q;

endmodule

[rtl/sirs_datapath.sv]
// Datapath of the radix symbols unit: magnitude register, radix divider
// (four quotient bits a cycle), digit stack and output payload register.
// Depends on sirs_pkg.
`timescale 1ns / 1ps

module sirs_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sirs_pkg::sirs_cmd_t               cmd,
	input  logic [sirs_pkg::NUMBER_WIDTH-1:0] number,
	input  logic [sirs_pkg::BASE_W-1:0]       base_size,
	input  logic [sirs_pkg::CFG_W-1:0]        symbols_low,
	input  logic [sirs_pkg::CFG_W-1:0]        symbols_high,
	output sirs_pkg::sirs_stat_t              stat,
	output logic [sirs_pkg::SYM_W-1:0]        symbol,
	output logic                              last
);
	import sirs_pkg::*;

	logic                    neg_q;
	logic [NUMBER_WIDTH-1:0] mag_q;
	logic [BASE_W-1:0]       rem_q;
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIGIT_W-1:0]      stack_q [NUMBER_WIDTH];
	logic [DIGIT_W-1:0]      rd_q;
	logic [SYM_W-1:0]        sym_q;
	logic                    last_q;

	logic [NUMBER_WIDTH-1:0] mag_nx;
	logic [BASE_W-1:0]       rem_nx;
	logic [CNT_W-1:0]        cnt_m1;
	logic                    digit_done;

	// Restoring division steps; remainder stays below the radix.
	always_comb begin
		logic q;
		rem_nx = rem_q;
		mag_nx = mag_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			rem_nx = {rem_nx[BASE_W-2:0], mag_nx[NUMBER_WIDTH-1]};
			q      = (rem_nx >= base_size);
			mag_nx = {mag_nx[NUMBER_WIDTH-2:0], q};
			if (q)
				rem_nx = rem_nx - base_size;
		end
	end

	assign digit_done = (step_q == STEP_W'(DIV_CYCLES - 1));
	assign cnt_m1     = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
		end else begin
			if (cmd.div_start) begin
				cnt_q  <= '0;
				step_q <= '0;
			end else if (cmd.div_en) begin
				if (digit_done) begin
					step_q <= '0;
					cnt_q  <= cnt_q + CNT_W'(1);
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= number[NUMBER_WIDTH-1];
			mag_q <= number[NUMBER_WIDTH-1] ? (~number + NUMBER_WIDTH'(1)) : number;
		end else if (cmd.div_en) begin
			mag_q <= mag_nx;
		end
		if (cmd.div_start || (cmd.div_en && digit_done))
			rem_q <= '0;
		else if (cmd.div_en)
			rem_q <= rem_nx;
		if (cmd.out_load) begin
			sym_q  <= cmd.out_minus ? SYM_MINUS : symbol_at(symbols_low, symbols_high, rd_q);
			last_q <= !cmd.out_minus && (cnt_q == CNT_W'(1));
		end
	end

	// Digit stack: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.div_en && digit_done)
			stack_q[cnt_q[STACK_AW-1:0]] <= rem_nx[DIGIT_W-1:0];
		if (cmd.rd_en)
			rd_q <= stack_q[cnt_m1[STACK_AW-1:0]];
	end

	assign stat.neg        = neg_q;
	assign stat.digit_done = digit_done;
	assign stat.conv_done  = digit_done &&
		((mag_nx == '0) || (cnt_q == CNT_W'(NUMBER_WIDTH - 1)));
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.cnt_one    = (cnt_q == CNT_W'(1));
	assign stat.cnt_full   = (cnt_q == CNT_W'(NUMBER_WIDTH));
	assign symbol          = sym_q;
	assign last            = last_q;

endmodule

[rtl/sirs_ctrl.sv]
// Controller of the radix symbols unit: sequences check, division,
// sign and symbol emission, and owns the output valid flag.
// Depends on sirs_pkg and the unit's assertion macro header.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_symbols_unit_macros.svh"

module sirs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 alpha_ok,
	input  sirs_pkg::sirs_stat_t stat,
	output sirs_pkg::sirs_cmd_t  cmd
);
	import sirs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SIGN  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (alpha_ok) begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_en = 1'b1;
				if (stat.conv_done)
					state_nx = S_SIGN;
			end
			S_SIGN: begin
				if (!stat.neg) begin
					state_nx = S_READ;
				end else if (out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_minus = 1'b1;
					state_nx      = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nx  = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.cnt_dec  = 1'b1;
					state_nx     = stat.cnt_one ? S_IDLE : S_READ;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	`SIRS_ASSERT_NEXT(a_check_exit, clk, arst_n, state_q == S_CHECK, state_q == S_IDLE || state_q == S_DIV)
	`SIRS_ASSERT_IMPLY(a_stack_room, clk, arst_n, state_q == S_DIV && stat.digit_done, !stat.cnt_full)
	`SIRS_ASSERT_IMPLY(a_read_nonempty, clk, arst_n, state_q == S_READ, !stat.cnt_zero)
	`SIRS_ASSERT_NEXT(a_last_to_idle, clk, arst_n, state_q == S_EMIT && cmd.out_load && stat.cnt_one, state_q == S_IDLE && m_tvalid)

endmodule

[rtl/signed_integer_to_radix_symbols_unit.sv]
// Top level of the signed integer to radix symbols unit.
// Depends on sirs_pkg, sirs_cfg, sirs_datapath and sirs_ctrl.
//
//   channel   | direction | payload
//   ----------+-----------+------------------------------------------------
//   s_*       | in        | s_tdata[31:0] = number (signed)
//   m_*       | out       | m_tdata[7:0] = symbol, m_tlast = last
//   wr_*      | in        | wr_index selects base_size/symbols_low/_high
//
// Sequence: a request is accepted, the alphabet is checked, the divider forms
// each digit (4 quotient bits a cycle), then the sign state runs and each
// symbol takes a stack read and an output load.
// An invalid alphabet drops the request after the check cycle.
// Reset: arst_n clears the controller, counters and output valid at once;
// the configuration returns to radix 10 and "0123456789ABCDEF".
// Stalls: m_tready low holds the output register and the symbol sequence.
`timescale 1ns / 1ps

module signed_integer_to_radix_symbols_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sirs_pkg::NUMBER_WIDTH-1:0] s_tdata,  // [31:0] number
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sirs_pkg::SYM_W-1:0]        m_tdata,  // [7:0] symbol
	output logic                              m_tlast,
	input  logic                              wr_en,
	input  logic [sirs_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [sirs_pkg::CFG_W-1:0]        wr_data
);
	import sirs_pkg::*;

	logic [BASE_W-1:0] base_size;
	logic [CFG_W-1:0]  symbols_low;
	logic [CFG_W-1:0]  symbols_high;
	logic              alpha_ok;
	sirs_cmd_t         cmd;
	sirs_stat_t        stat;

	// Configuration registers and the alphabet legality check.
	sirs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.base_size    (base_size),
		.symbols_low  (symbols_low),
		.symbols_high (symbols_high),
		.alpha_ok     (alpha_ok)
	);

	// Divider, digit stack and output payload.
	sirs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.number       (s_tdata),
		.base_size    (base_size),
		.symbols_low  (symbols_low),
		.symbols_high (symbols_high),
		.stat         (stat),
		.symbol       (m_tdata),
		.last         (m_tlast)
	);

	// Sequencer: accept, check, divide, emit sign and digits.
	sirs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.alpha_ok (alpha_ok),
		.stat     (stat),
		.cmd      (cmd)
	);

endmodule

[sim/tb_signed_integer_to_radix_symbols_unit.sv]
// Self-checking bench for signed_integer_to_radix_symbols_unit: a table of directed
// requests, then random radix/alphabet settings with random numbers, all scored per symbol.
// Depends on sirs_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_symbols_unit;
	import sirs_pkg::*;

	localparam int CLK_HALF           = 6;
	localparam int RESET_CYCLES       = 4;
	// Invalid alphabets drop a request right after the check cycle.
	localparam int SETTLE_CYCLES      = 16;
	// Enough for the longest conversion, of 33 symbols.
	localparam int TAIL_CYCLES        = 400;
	localparam int LIMIT_CYCLES       = 1_000_000;
	localparam int REQUESTS_PER_PHASE = 145;
	localparam int MAX_REPORTS        = 10;
	localparam int TXT_CHARS          = 12;
	// Index with no register behind it; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
	} symbol_beat_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_NUM, ROW_CHK} row_kind_t;

	// One line of the directed table: a register write, a number scored by the
	// predictor, or a number whose symbols are typed in (zero bytes are padding).
	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_W-1:0]          data;
		logic [NUMBER_WIDTH-1:0]   num;
		logic [TXT_CHARS*8-1:0]    txt;
	} stim_row_t;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [NUMBER_WIDTH-1:0] s_tdata  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [SYM_W-1:0]        m_tdata;
	logic                    m_tlast;
	logic                    wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]    wr_index = '0;
	logic [CFG_W-1:0]        wr_data  = '0;

	signed_integer_to_radix_symbols_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Bench copy of the configuration, updated once a write has landed.
	logic [BASE_W-1:0]  radix_q  = BASE_SIZE_RST;
	logic [CFG_W-1:0]   alpha_lo = SYMBOLS_LOW_RST;
	logic [CFG_W-1:0]   alpha_hi = SYMBOLS_HIGH_RST;
	// Digits of the last conversion, least significant first.
	logic [DIGIT_W-1:0] digit_buf [NUMBER_WIDTH];
	logic [CNT_W-1:0]   digit_total = '0;

	symbol_beat_t pending_symbols [$];
	stim_row_t    directed [$];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned cycles, requests, usable_requests, symbols_seen;
	int unsigned register_writes, settings, mismatches;

	function automatic logic [SYM_W-1:0] glyph(input logic [DIGIT_W-1:0] idx);
		return idx[DIGIT_W-1] ? alpha_hi[idx[DIGIT_W-2:0]*SYM_W +: SYM_W]
			: alpha_lo[idx[DIGIT_W-2:0]*SYM_W +: SYM_W];
	endfunction

	// Radix in range, no sign or NUL among the symbols in use, no repeats.
	function automatic bit alphabet_usable();
		logic [SYM_W-1:0] s;
		if (radix_q < 2 || radix_q > MAX_BASE)
			return 1'b0;
		for (int i = 0; i < radix_q; i++) begin
			s = glyph(i[DIGIT_W-1:0]);
			if (s == SYM_NUL || s == SYM_PLUS || s == SYM_MINUS)
				return 1'b0;
			for (int j = i + 1; j < radix_q; j++)
				if (glyph(j[DIGIT_W-1:0]) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queue the symbols one number must produce under the current settings.
	function automatic void predict_symbols(input logic [NUMBER_WIDTH-1:0] num);
		logic [NUMBER_WIDTH-1:0] mag;
		logic [NUMBER_WIDTH-1:0] radix;
		logic [NUMBER_WIDTH-1:0] rem;
		int n;
		if (!alphabet_usable())
			return;
		radix = radix_q;
		// Unsigned magnitude: the most negative value maps onto itself.
		mag = num[NUMBER_WIDTH-1] ? -num : num;
		n = 0;
		do begin
			rem = mag % radix;
			digit_buf[n] = rem[DIGIT_W-1:0];
			mag = mag / radix;
			n++;
		end while (mag != 0 && n < NUMBER_WIDTH);
		digit_total = n[CNT_W-1:0];
		if (num[NUMBER_WIDTH-1])
			pending_symbols.push_back('{SYM_MINUS, 1'b0});
		for (int k = n - 1; k >= 0; k--)
			pending_symbols.push_back('{glyph(digit_buf[k]), k == 0});
	endfunction

	task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		directed.push_back(r);
	endtask

	task automatic put_num(input logic [NUMBER_WIDTH-1:0] num);
		stim_row_t r;
		r = '0;
		r.kind = ROW_NUM;
		r.num = num;
		directed.push_back(r);
	endtask

	task automatic put_chk(input logic [NUMBER_WIDTH-1:0] num,
			input logic [TXT_CHARS*8-1:0] txt);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CHK;
		r.num = num;
		r.txt = txt;
		directed.push_back(r);
	endtask

	// Write one register with the unit idle: drop valid, drain, settle, write.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		s_tvalid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_BASE_SIZE:    radix_q  = data[BASE_W-1:0];
			CFG_SYMBOLS_LOW:  alpha_lo = data;
			CFG_SYMBOLS_HIGH: alpha_hi = data;
			default: ;
		endcase
		register_writes++;
	endtask

	// Offer one request, hold it until accepted, then queue what it must produce.
	// Entered and left at a falling edge; valid stays high on return.
	task automatic send_number(input logic [NUMBER_WIDTH-1:0] num, input bit typed,
			input logic [TXT_CHARS*8-1:0] txt);
		int tail;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= num;
		do @(posedge clk); while (!s_tready);
		requests++;
		if (alphabet_usable())
			usable_requests++;
		if (!typed)
			predict_symbols(num);
		else begin
			// The lowest non-zero byte is the final symbol.
			tail = -1;
			for (int i = 0; i < TXT_CHARS && tail < 0; i++)
				if (txt[i*8 +: 8] != SYM_NUL)
					tail = i;
			for (int i = TXT_CHARS - 1; i >= 0; i--)
				if (txt[i*8 +: 8] != SYM_NUL)
					pending_symbols.push_back('{txt[i*8 +: 8], i == tail});
		end
		@(negedge clk);
	endtask

	// Receiver backpressure, redrawn every cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Score every accepted symbol against the oldest expectation.
	always @(posedge clk) begin : check_symbols
		symbol_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			symbols_seen++;
			if (pending_symbols.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected symbol %02h last %0b", $time, m_tdata, m_tlast);
			end else begin
				want = pending_symbols.pop_front();
				if (m_tdata !== want.sym || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected symbol %02h last %0b, got %02h last %0b",
							$time, want.sym, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d symbols outstanding",
				cycles, pending_symbols.size());
			$display("tb_signed_integer_to_radix_symbols_unit failed");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t               row;
		int                      ph, seg, items, pick, pos, other, goal;
		logic [SYM_W-1:0]        alpha [16];
		bit                      taken [256];
		logic [SYM_W-1:0]        b;
		logic [BASE_W-1:0]       base;
		logic [CFG_W-1:0]        lo, hi, word;
		logic [NUMBER_WIDTH-1:0] num;
		longint unsigned         p;

		// Reset settings: radix 10, "0123456789ABCDEF".
		put_chk(32'h0000_0000, "0");
		put_chk(32'h7FFF_FFFF, "2147483647");
		put_chk(32'h8000_0000, "-2147483648");
		put_chk(32'hFFFF_FFFF, "-1");
		put_num(32'd10);
		// Radix 2; bits above the register width are junk and must be dropped.
		put_cfg(CFG_BASE_SIZE, 64'hFFFF_FFFF_FFFF_FFE2);
		put_num(32'h8000_0000);
		put_num(32'h7FFF_FFFF);
		put_num(32'hFFFF_FFFB);
		put_cfg(CFG_BASE_SIZE, 64'd16);
		put_chk(32'h7FFF_FFFF, "7FFFFFFF");
		put_chk(32'h8000_0000, "-80000000");
		put_chk(32'h0000_00FF, "FF");
		// Write to the unused index: nothing may change.
		put_cfg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		put_chk(32'hFFFF_FF00, "-100");
		// Radix out of range on both sides: request is swallowed.
		put_cfg(CFG_BASE_SIZE, 64'd1);
		put_chk(32'd7, "");
		put_cfg(CFG_BASE_SIZE, 64'd0);
		put_chk(32'd7, "");
		put_cfg(CFG_BASE_SIZE, 64'd17);
		put_chk(32'hFFFF_FFF9, "");
		// Radix 3 with a plus, a minus, a NUL, then a repeat among the symbols.
		put_cfg(CFG_BASE_SIZE, 64'd3);
		put_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_0063_2B61);
		put_chk(32'd5, "");
		put_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_002D_6261);
		put_chk(32'd5, "");
		put_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_0063_6200);
		put_chk(32'd5, "");
		put_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_0061_6261);
		put_chk(32'd5, "");
		// Bad bytes past the radix are never looked at.
		put_cfg(CFG_SYMBOLS_LOW, 64'h2B2D_0000_0063_6261);
		put_num(32'd5);
		put_num(32'h8000_0000);
		// Full sixteen-symbol lowercase alphabet.
		put_cfg(CFG_BASE_SIZE, 64'd16);
		put_cfg(CFG_SYMBOLS_LOW, 64'h6867_6665_6463_6261);
		put_cfg(CFG_SYMBOLS_HIGH, 64'h706F_6E6D_6C6B_6A69);
		put_chk(32'h8000_0000, "-iaaaaaaa");
		put_num(32'h1234_5678);
		// Repeat across the two words, then NUL in the top symbol.
		put_cfg(CFG_SYMBOLS_HIGH, 64'h706F_6E6D_6C6B_6A61);
		put_chk(32'd1, "");
		put_cfg(CFG_SYMBOLS_HIGH, 64'h006F_6E6D_6C6B_6A69);
		put_chk(32'd1, "");

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 54;
		foreach (directed[i]) begin
			row = directed[i];
			if (row.kind == ROW_CFG)
				write_register(row.idx, row.data);
			else
				send_number(row.num, row.kind == ROW_CHK, row.txt);
		end

		// Random part: three backpressure phases, each a run of settings.
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			goal = int'(requests) + REQUESTS_PER_PHASE;
			seg = 0;
			while (int'(requests) < goal) begin
				// Pick the radix: mostly legal, with both extremes on a rota.
				if ($urandom_range(99) < 8)
					base = $urandom_range(1) ? $urandom_range(1) : $urandom_range(17, 31);
				else if (seg % 4 == 0)
					base = 2;
				else if (seg % 4 == 1)
					base = MAX_BASE;
				else
					base = $urandom_range(2, MAX_BASE);

				// Draw sixteen distinct legal bytes.
				foreach (taken[k])
					taken[k] = 1'b0;
				for (int i = 0; i < 16; i++) begin
					do b = $urandom_range(1, 255);
					while (taken[b] || b == SYM_PLUS || b == SYM_MINUS);
					taken[b] = 1'b1;
					alpha[i] = b;
				end

				// Now and then spoil one symbol that is in use.
				if (base >= 2 && base <= MAX_BASE && $urandom_range(99) < 12) begin
					pos = $urandom_range(base - 1);
					case ($urandom_range(3))
						0: alpha[pos] = SYM_NUL;
						1: alpha[pos] = SYM_PLUS;
						2: alpha[pos] = SYM_MINUS;
						default: begin
							other = (pos + $urandom_range(1, base - 1)) % base;
							alpha[pos] = alpha[other];
						end
					endcase
				end

				for (int i = 0; i < 8; i++) begin
					lo[i*8 +: 8] = alpha[i];
					hi[i*8 +: 8] = alpha[i+8];
				end
				word = {$urandom, $urandom};
				word[BASE_W-1:0] = base;
				write_register(CFG_BASE_SIZE, word);
				write_register(CFG_SYMBOLS_LOW, lo);
				write_register(CFG_SYMBOLS_HIGH, hi);
				if ($urandom_range(99) < 20)
					write_register(CFG_UNUSED, {$urandom, $urandom});
				settings++;

				// Swallowed requests only need a short burst; stop at the phase goal.
				items = alphabet_usable() ? 30 : 5;
				if (items > goal - int'(requests))
					items = goal - int'(requests);
				repeat (items) begin
					pick = $urandom_range(99);
					if (pick < 45)
						num = $urandom;
					else if (pick < 60) begin
						num = $urandom_range(40);
						if ($urandom_range(1))
							num = -num;
					end else if (pick < 70) begin
						case ($urandom_range(3))
							0: num = 32'h8000_0000;
							1: num = 32'h7FFF_FFFF;
							2: num = '0;
							default: num = '1;
						endcase
					end else begin
						// Around a power of the radix: digit-count boundaries.
						p = 1;
						repeat ($urandom_range(1, NUMBER_WIDTH - 1))
							if (p * radix_q <= 64'h8000_0000)
								p = p * radix_q;
						num = p[NUMBER_WIDTH-1:0] + $urandom_range(2) - 1;
						if ($urandom_range(1))
							num = -num;
					end
					send_number(num, 1'b0, '0);
				end
				seg++;
			end
		end

		// Drain, then let the unit run out its longest conversion.
		s_tvalid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("ran %0d requests (%0d with a usable alphabet) over %0d random settings",
			requests, usable_requests, settings);
		$display("scored %0d symbols, %0d register writes, %0d mismatches",
			symbols_seen, register_writes, mismatches);
		if (mismatches == 0 && pending_symbols.size() == 0)
			$display("tb_signed_integer_to_radix_symbols_unit passed");
		else
			$display("tb_signed_integer_to_radix_symbols_unit failed");
		$finish;
	end

endmodule
